### rtl/rkv_pkg.sv
package rkv_pkg;

  // Turn codes reported per poll
  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_ev_t;

  // Press codes reported per poll
  typedef enum logic [2:0] {
    PRESS_NONE        = 3'd0,
    PRESS_CLICK       = 3'd1,
    PRESS_DOUBLE      = 3'd2,
    PRESS_LONG        = 3'd3,
    PRESS_DOUBLE_LONG = 3'd4
  } press_ev_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_VALUE_MIN    = 3'd0;
  localparam logic [2:0] REG_VALUE_MAX    = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE    = 3'd2;
  localparam logic [2:0] REG_FAST_MS      = 3'd3;
  localparam logic [2:0] REG_VERY_FAST_MS = 3'd4;
  localparam logic [2:0] REG_SHORT_MS     = 3'd5;
  localparam logic [2:0] REG_LONG_MS      = 3'd6;
  localparam logic [2:0] REG_DOUBLE_MS    = 3'd7;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0]  BYTE_LEFT_LIMIT  = 8'd127;
  localparam logic [31:0] DEBOUNCE_MS      = 32'd20;
  localparam logic [3:0]  VERY_FAST_FACTOR = 4'd10;
  localparam logic [3:0]  FAST_FACTOR      = 4'd5;

  // x / 10 == (x * RECIP_10) >> 19 for every 16-bit x
  localparam logic [31:0] RECIP_10 = 32'd52429;

  localparam int unsigned MAG_W   = 15;  // detent count times step size
  localparam int unsigned INCR_W  = 21;  // signed increment after scaling
  localparam int unsigned ACC_W   = 22;  // accumulator plus increment
  localparam int unsigned OUT_DEPTH = 2;

  // Input item
  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  turn_byte;
    logic        button_level;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] knob_value;
    turn_ev_t           turn_event;
    press_ev_t          press_event;
    logic               active;
  } out_item_t;

  // Classified poll handed from front to back
  typedef struct packed {
    logic signed [INCR_W-1:0] incr;
    logic [3:0]               incr_res;   // floored residue of incr mod 10
    logic                     very_fast;
    logic                     fast;
    turn_ev_t                 turn_ev;
    press_ev_t                press_ev;
    logic                     active;
  } q_item_t;

  // Register file contents
  typedef struct packed {
    logic signed [15:0] value_min;
    logic signed [15:0] value_max;
    logic [3:0]         min_res;
    logic [3:0]         max_res;
    logic [7:0]         step_size;
    logic [15:0]        fast_ms;
    logic [15:0]        very_fast_ms;
    logic [15:0]        short_ms;
    logic [15:0]        long_ms;
    logic [15:0]        double_ms;
  } cfg_t;

  // Remainder of an unsigned 16-bit value by ten
  function automatic logic [3:0] mod10_u16(input logic [15:0] x);
    logic [31:0] prod;
    logic [12:0] q;
    logic [15:0] r;
    prod = 32'(x) * RECIP_10;
    q    = prod[31:19];
    r    = x - (16'({q, 3'b000}) + 16'({q, 1'b0}));
    return r[3:0];
  endfunction

  // Floored residue mod ten of a signed 16-bit value (always 0..9)
  function automatic logic [3:0] fmod10_s16(input logic [15:0] s);
    logic [3:0] m;
    // offset by 32768, which is 8 mod 10
    m = mod10_u16({~s[15], s[14:0]});
    return (m >= 4'd8) ? (m - 4'd8) : (m + 4'd2);
  endfunction

endpackage

### rtl/rkv_fifo.sv
module rkv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Store an entry on each write transfer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/rkv_regs.sv
module rkv_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rkv_pkg::ADDR_W-1:0]   paddr,
  input  logic [rkv_pkg::DATA_W-1:0]   pwdata,
  output logic [rkv_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rkv_pkg::cfg_t                cfg
);

  rkv_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write registers; keep the mod-10 residue of each clamp limit alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_min    <= '0;
      cfg_r.value_max    <= '0;
      cfg_r.min_res      <= '0;
      cfg_r.max_res      <= '0;
      cfg_r.step_size    <= 8'd1;
      cfg_r.fast_ms      <= '0;
      cfg_r.very_fast_ms <= '0;
      cfg_r.short_ms     <= 16'd300;
      cfg_r.long_ms      <= 16'd500;
      cfg_r.double_ms    <= 16'd400;
    end else if (wr_en) begin
      unique case (idx)
        rkv_pkg::REG_VALUE_MIN: begin
          cfg_r.value_min <= pwdata[15:0];
          cfg_r.min_res   <= rkv_pkg::fmod10_s16(pwdata[15:0]);
        end
        rkv_pkg::REG_VALUE_MAX: begin
          cfg_r.value_max <= pwdata[15:0];
          cfg_r.max_res   <= rkv_pkg::fmod10_s16(pwdata[15:0]);
        end
        rkv_pkg::REG_STEP_SIZE:    cfg_r.step_size    <= pwdata[7:0];
        rkv_pkg::REG_FAST_MS:      cfg_r.fast_ms      <= pwdata[15:0];
        rkv_pkg::REG_VERY_FAST_MS: cfg_r.very_fast_ms <= pwdata[15:0];
        rkv_pkg::REG_SHORT_MS:     cfg_r.short_ms     <= pwdata[15:0];
        rkv_pkg::REG_LONG_MS:      cfg_r.long_ms      <= pwdata[15:0];
        rkv_pkg::REG_DOUBLE_MS:    cfg_r.double_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back, limits sign extended
  always_comb begin
    unique case (idx)
      rkv_pkg::REG_VALUE_MIN:    prdata = 32'(cfg_r.value_min);
      rkv_pkg::REG_VALUE_MAX:    prdata = 32'(cfg_r.value_max);
      rkv_pkg::REG_STEP_SIZE:    prdata = 32'(cfg_r.step_size);
      rkv_pkg::REG_FAST_MS:      prdata = 32'(cfg_r.fast_ms);
      rkv_pkg::REG_VERY_FAST_MS: prdata = 32'(cfg_r.very_fast_ms);
      rkv_pkg::REG_SHORT_MS:     prdata = 32'(cfg_r.short_ms);
      rkv_pkg::REG_LONG_MS:      prdata = 32'(cfg_r.long_ms);
      rkv_pkg::REG_DOUBLE_MS:    prdata = 32'(cfg_r.double_ms);
      default:                   prdata = '0;
    endcase
  end

endmodule

### rtl/rkv_front.sv
module rkv_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rkv_pkg::cfg_t      cfg,
  input  logic               push,
  output logic               full,
  input  rkv_pkg::in_item_t  in_data,
  input  logic               q_pop,
  output logic               q_push,
  output rkv_pkg::q_item_t   q_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Credit count: items in the two front stages plus the queue
  logic [CNT_W-1:0] credit_r;
  logic             accept;

  // Turn and button state
  logic [31:0] last_turn_r, press_start_r;
  logic        prev_level_r, long_rep_r, first_pend_r, second_act_r;

  // Stage A registers
  logic                   a_vld_r;
  logic [rkv_pkg::MAG_W-1:0] a_mag_r;
  logic                   a_left_r, a_vf_r, a_fast_r, a_active_r;
  rkv_pkg::turn_ev_t      a_turn_r;
  rkv_pkg::press_ev_t     a_press_r;

  // Stage B registers
  logic             b_vld_r;
  rkv_pkg::q_item_t b_item_r;

  // Stage A combinational terms
  logic                      left, nz, vf, fast, pressed, rel_edge, prs_edge;
  logic [31:0]               gap, held, press_start_nxt;
  logic                      long_rep_nxt, first_pend_nxt, second_act_nxt;
  logic [rkv_pkg::MAG_W-1:0] mag_nxt;
  rkv_pkg::press_ev_t        press_nxt;
  rkv_pkg::turn_ev_t         turn_nxt;

  // Stage B combinational terms
  logic [3:0]                   m10, res_plain;
  logic [rkv_pkg::INCR_W-1:0]   scaled;
  rkv_pkg::q_item_t             b_item_nxt;

  assign full   = (credit_r == CNT_W'(QUEUE_DEPTH));
  assign accept = push && !full;
  assign q_push = b_vld_r;
  assign q_data = b_item_r;

  // Track outstanding items against the queue size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (accept && !q_pop) begin
      credit_r <= credit_r + 1'b1;
    end else if (q_pop && !accept) begin
      credit_r <= credit_r - 1'b1;
    end
  end

  // Classify turn and button for the incoming poll
  always_comb begin
    left = in_data.turn_byte > rkv_pkg::BYTE_LEFT_LIMIT;
    nz   = (cfg.step_size != '0) && (left || (in_data.turn_byte != '0));
    gap  = in_data.now_ms - last_turn_r;
    vf   = nz && (gap < 32'(cfg.very_fast_ms));
    fast = nz && !vf && (gap < 32'(cfg.fast_ms));
    mag_nxt = left ? rkv_pkg::MAG_W'(cfg.step_size)
                   : rkv_pkg::MAG_W'(in_data.turn_byte[6:0]) *
                     rkv_pkg::MAG_W'(cfg.step_size);
    if (left) begin
      turn_nxt = rkv_pkg::TURN_LEFT;
    end else if (nz) begin
      turn_nxt = rkv_pkg::TURN_RIGHT;
    end else begin
      turn_nxt = rkv_pkg::TURN_NONE;
    end

    pressed  = !in_data.button_level;
    rel_edge = in_data.button_level && !prev_level_r;
    prs_edge = !in_data.button_level && prev_level_r;

    press_start_nxt = prs_edge ? in_data.now_ms : press_start_r;
    long_rep_nxt    = prs_edge ? 1'b0 : long_rep_r;
    second_act_nxt  = prs_edge ? first_pend_r : second_act_r;
    if (rel_edge) begin
      second_act_nxt = 1'b0;
    end
    first_pend_nxt = first_pend_r;
    press_nxt      = rkv_pkg::PRESS_NONE;
    held           = in_data.now_ms - press_start_nxt;

    // Report a pending click once the double-click window closes
    if (first_pend_r && !second_act_nxt && (held > 32'(cfg.double_ms))) begin
      press_nxt      = rkv_pkg::PRESS_CLICK;
      first_pend_nxt = 1'b0;
    end
    // Short release: arm a click or complete a double click
    if (rel_edge && (held <= 32'(cfg.short_ms)) && (held > rkv_pkg::DEBOUNCE_MS)) begin
      if (!first_pend_nxt) begin
        first_pend_nxt = 1'b1;
      end else begin
        press_nxt      = rkv_pkg::PRESS_DOUBLE;
        first_pend_nxt = 1'b0;
      end
    end
    // Long hold, reported once per press
    if (pressed && (held >= 32'(cfg.long_ms)) && !long_rep_nxt) begin
      press_nxt      = first_pend_nxt ? rkv_pkg::PRESS_DOUBLE_LONG : rkv_pkg::PRESS_LONG;
      first_pend_nxt = 1'b0;
      long_rep_nxt   = 1'b1;
    end
  end

  // Update poll state and load stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r       <= 1'b0;
      last_turn_r   <= '0;
      press_start_r <= '0;
      prev_level_r  <= 1'b1;
      long_rep_r    <= 1'b0;
      first_pend_r  <= 1'b0;
      second_act_r  <= 1'b0;
    end else begin
      a_vld_r <= accept;
      if (accept) begin
        if (nz) begin
          last_turn_r <= in_data.now_ms;
        end
        press_start_r <= press_start_nxt;
        prev_level_r  <= in_data.button_level;
        long_rep_r    <= long_rep_nxt;
        first_pend_r  <= first_pend_nxt;
        second_act_r  <= second_act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mag_r    <= mag_nxt;
      a_left_r   <= left;
      a_vf_r     <= vf;
      a_fast_r   <= fast;
      a_turn_r   <= turn_nxt;
      a_press_r  <= press_nxt;
      a_active_r <= pressed || nz || left;
    end
  end

  // Scale the increment and find its residue mod ten
  always_comb begin
    m10       = rkv_pkg::mod10_u16(16'(a_mag_r));
    res_plain = (a_left_r && (m10 != '0)) ? (rkv_pkg::VERY_FAST_FACTOR - m10) : m10;
    if (a_vf_r) begin
      scaled = (rkv_pkg::INCR_W'(a_mag_r) << 3) + (rkv_pkg::INCR_W'(a_mag_r) << 1);
    end else if (a_fast_r) begin
      scaled = (rkv_pkg::INCR_W'(a_mag_r) << 2) + rkv_pkg::INCR_W'(a_mag_r);
    end else begin
      scaled = rkv_pkg::INCR_W'(a_mag_r);
    end
    b_item_nxt.incr = a_left_r ? -$signed(scaled) : $signed(scaled);
    if (a_vf_r) begin
      b_item_nxt.incr_res = '0;
    end else if (a_fast_r) begin
      b_item_nxt.incr_res = a_mag_r[0] ? rkv_pkg::FAST_FACTOR : 4'd0;
    end else begin
      b_item_nxt.incr_res = res_plain;
    end
    b_item_nxt.very_fast = a_vf_r;
    b_item_nxt.fast      = a_fast_r;
    b_item_nxt.turn_ev   = a_turn_r;
    b_item_nxt.press_ev  = a_press_r;
    b_item_nxt.active    = a_active_r;
  end

  // Load stage B, which feeds the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      b_item_r <= b_item_nxt;
    end
  end

endmodule

### rtl/rkv_back.sv
module rkv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rkv_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  rkv_pkg::q_item_t    q_data,
  output logic                q_pop,
  input  logic                o_full,
  output logic                o_push,
  output rkv_pkg::out_item_t  o_data
);

  logic signed [15:0] acc_r, acc_nxt;
  logic [3:0]         acc_res_r, acc_res_nxt;

  logic [4:0]                       vsum;
  logic [3:0]                       vres, r, base, period, res_rnd;
  logic                             fix;
  logic signed [rkv_pkg::ACC_W-1:0] v_s, rnd_s, lo_s, hi_s, c1_s, c2_s;
  logic [3:0]                       c1_res, c2_res;

  assign q_pop  = !q_empty && !o_full;
  assign o_push = q_pop;

  // Add, round toward zero to the acceleration multiple, clamp
  always_comb begin
    vsum = 5'(acc_res_r) + 5'(q_data.incr_res);
    vres = (vsum >= 5'(rkv_pkg::VERY_FAST_FACTOR))
           ? 4'(vsum - 5'(rkv_pkg::VERY_FAST_FACTOR)) : vsum[3:0];
    if (q_data.very_fast) begin
      r      = vres;
      period = rkv_pkg::VERY_FAST_FACTOR;
    end else if (q_data.fast) begin
      r      = (vres >= rkv_pkg::FAST_FACTOR) ? (vres - rkv_pkg::FAST_FACTOR) : vres;
      period = rkv_pkg::FAST_FACTOR;
    end else begin
      r      = '0;
      period = '0;
    end

    v_s   = rkv_pkg::ACC_W'(acc_r) + rkv_pkg::ACC_W'(q_data.incr);
    fix   = v_s[rkv_pkg::ACC_W-1] && (r != '0);
    rnd_s = v_s - rkv_pkg::ACC_W'($signed({1'b0, r}))
                + (fix ? rkv_pkg::ACC_W'($signed({1'b0, period})) : '0);

    base = vres - r;
    if (q_data.very_fast) begin
      res_rnd = '0;
    end else if (q_data.fast) begin
      res_rnd = fix ? ((base == '0) ? rkv_pkg::FAST_FACTOR : 4'd0) : base;
    end else begin
      res_rnd = vres;
    end

    lo_s = rkv_pkg::ACC_W'(cfg.value_min);
    hi_s = rkv_pkg::ACC_W'(cfg.value_max);
    // Raise to the lower limit, then lower to the upper one
    if (rnd_s < lo_s) begin
      c1_s   = lo_s;
      c1_res = cfg.min_res;
    end else begin
      c1_s   = rnd_s;
      c1_res = res_rnd;
    end
    if (c1_s > hi_s) begin
      c2_s   = hi_s;
      c2_res = cfg.max_res;
    end else begin
      c2_s   = c1_s;
      c2_res = c1_res;
    end
    acc_nxt     = c2_s[15:0];
    acc_res_nxt = c2_res;

    o_data.knob_value  = acc_nxt;
    o_data.turn_event  = q_data.turn_ev;
    o_data.press_event = q_data.press_ev;
    o_data.active      = q_data.active;
  end

  // Hold the accumulator and its residue mod ten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      acc_res_r <= '0;
    end else if (q_pop) begin
      acc_r     <= acc_nxt;
      acc_res_r <= acc_res_nxt;
    end
  end

endmodule

### rtl/rotary_knob_value_and_gesture_unit.sv
// Rotary knob value and gesture unit.
// Input queue port: drive in_data (timestamp, turn byte, button level) with push;
// an item transfers on a clock edge with push high and full low.
// Result queue port: while empty is low, out_data holds the oldest result
// (knob value, turn event, press event, active); it transfers on an edge with
// pop high and empty low. Every poll yields exactly one result, in order.
// Configuration: APB write/read at byte address 4*index; pready is tied high.
// A result passes stage A, stage B, the middle queue and the output queue.
// Throughput: one poll per cycle, sustained while the result side is not stalled.
// The front (turn/button classification, two stages) runs ahead of the back
// (accumulate, round, clamp) through a queue of QUEUE_DEPTH entries; full is
// driven from a credit count over both front stages and that queue, so one
// item per cycle needs QUEUE_DEPTH of at least 4.
// When pop stays low, results collect in a two-entry output queue, then the
// middle queue fills and full rises; nothing is dropped.
// Synchronous reset (rst_n low) empties both queues, restores register
// defaults and clears the knob value and all gesture state.
module rotary_knob_value_and_gesture_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  rkv_pkg::in_item_t           in_data,
  input  logic                        pop,
  output logic                        empty,
  output rkv_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rkv_pkg::ADDR_W-1:0]  paddr,
  input  logic [rkv_pkg::DATA_W-1:0]  pwdata,
  output logic [rkv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  rkv_pkg::cfg_t      cfg;
  logic               q_push, q_pop, q_full, q_empty;
  rkv_pkg::q_item_t   q_wdata, q_rdata;
  logic               o_push, o_full;
  rkv_pkg::out_item_t o_wdata;

  rkv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rkv_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  rkv_fifo #(
    .WIDTH ($bits(rkv_pkg::q_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  rkv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_data  (o_wdata)
  );

  rkv_fifo #(
    .WIDTH ($bits(rkv_pkg::out_item_t)),
    .DEPTH (rkv_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (o_push),
    .wr_data (o_wdata),
    .rd_en   (pop),
    .rd_data (out_data),
    .full    (o_full),
    .empty   (empty)
  );

  // The credit count keeps the middle queue from overflowing; q_full is spare
  // headroom and only qualifies the write enable inside the queue.
  logic unused_q_full;
  assign unused_q_full = q_full;

endmodule

### rtl/rkv_checker.sv
module rkv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input rkv_pkg::out_item_t          out_data
);

  // Reset leaves both queue ports idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result holds until it transfers
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before transfer");

  // Event codes stay within their defined sets
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_data.turn_event == rkv_pkg::TURN_NONE ||
                 out_data.turn_event == rkv_pkg::TURN_RIGHT ||
                 out_data.turn_event == rkv_pkg::TURN_LEFT) &&
                (out_data.press_event == rkv_pkg::PRESS_NONE ||
                 out_data.press_event == rkv_pkg::PRESS_CLICK ||
                 out_data.press_event == rkv_pkg::PRESS_DOUBLE ||
                 out_data.press_event == rkv_pkg::PRESS_LONG ||
                 out_data.press_event == rkv_pkg::PRESS_DOUBLE_LONG)))
    else $error("undefined event code on result");

  // Any reported turn marks the poll active
  a_turn_active: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.turn_event != rkv_pkg::TURN_NONE) |-> out_data.active)
    else $error("turn reported without active");

endmodule

bind rotary_knob_value_and_gesture_unit rkv_checker u_checker (.*);
